/* hdl/fvsb_pkg.sv */
// Shared types, codes and constants for the four-voice square synthesizer.
package fvsb_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_MULA,
        ST_MULB,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_BEEP  = 2'd3
    } cmd_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] WORD_TAG  = 2'b11;

    localparam logic [2:0] REG_MUTE             = 3'd0;
    localparam logic [2:0] REG_PHASE_PER_SAMPLE = 3'd1;
    localparam logic [2:0] REG_SAMPLES_PER_WORD = 3'd2;
    localparam logic [2:0] REG_FILTER_COEF      = 3'd3;
    localparam logic [2:0] REG_BEEP_INCREMENT   = 3'd4;
    localparam logic [2:0] REG_BEEP_SAMPLES     = 3'd5;

    localparam logic [31:0] RST_PHASE_PER_SAMPLE = 32'd676691285;
    localparam logic [15:0] RST_SAMPLES_PER_WORD = 16'd800;
    localparam logic [16:0] RST_FILTER_COEF      = 17'd1337;
    localparam logic [31:0] RST_BEEP_INCREMENT   = 32'd89478485;
    localparam logic [15:0] RST_BEEP_SAMPLES     = 16'd7200;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_CNT_W = 6;
    localparam int STEP_W    = 31;
    localparam int PHASE_W   = 32;
    localparam int VOL_W     = 13;
    localparam int SUM_W     = 16;
    localparam int ACC_W     = 34;
    localparam int MUL_X_W   = 34;
    localparam int MUL_Y_W   = 18;
    localparam int PROD_W    = 52;
    localparam int MUSIC_W   = 18;
    localparam int AUDIO_W   = 19;

    localparam logic [DIV_NUM_W-1:0] DIV_LIMIT = 40'h00_4000_0000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = 6'd39;

    localparam logic [16:0] COEF_ONE = 17'd65536;
    localparam logic signed [ACC_W-1:0] ACC_ROUND = 34'sd65535;
    localparam logic signed [AUDIO_W-1:0] BEEP_POS = 19'sd6000;
    localparam logic signed [AUDIO_W-1:0] BEEP_NEG = -19'sd6000;
    localparam logic signed [AUDIO_W-1:0] SAT_POS  = 19'sd32767;
    localparam logic signed [AUDIO_W-1:0] SAT_NEG  = -19'sd32767;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
        logic fits;
    } div_stat_t;

    function automatic logic [VOL_W-1:0] volume_of(input logic [2:0] code);
        logic [VOL_W-1:0] v;
        case (code)
            3'd0:    v = 13'd1000;
            3'd1:    v = 13'd2000;
            3'd2:    v = 13'd3000;
            3'd3:    v = 13'd4000;
            3'd4:    v = 13'd5000;
            3'd5:    v = 13'd6000;
            3'd6:    v = 13'd7000;
            default: v = 13'd8000;
        endcase
        return v;
    endfunction

endpackage

/* hdl/four_voice_square_synth_with_beep.sv */
// Top level: sequencer, voice state, filter, beep and output register.
//
// Input channel (in_valid/in_stall) takes one command per transaction.
// Start music, stop music and start beep act at once and produce no result.
// A sample tick produces exactly one output transaction (sample, word_taken,
// music_active) on the out_valid/out_stall channel.
// A tick steps through the sum, first multiply, second multiply, accumulate
// and output states before its result is registered; a tick that takes a
// pitch word of value 2 or more first waits in the divide state, where the
// restoring divider resolves one quotient bit per cycle. A tick while music
// is stopped, or one that takes an end word, goes straight to the output
// state. One shared multiplier forms the two filter products in consecutive
// cycles. in_stall stays high while a tick is in progress; a new command is
// taken only in the idle state, from the cycle after the result is registered.
// The output register holds a result until taken; while it is full and out_stall
// is high the finished tick waits and no new command enters.
// Configuration writes (cfg_valid/cfg_ready, always ready) go straight into their registers.
// Reset (rst_n low, asynchronous) stops music, clears voices, filter and beep
// state, and loads the default register values.
module four_voice_square_synth_with_beep
    import fvsb_pkg::*;
#(
    parameter int VOICE_COUNT = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [17:0]        word,
    input  logic [1:0]         word_kind,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic               word_taken,
    output logic               music_active,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    state_t state_reg, state_next;

    logic        mute_reg, mute_next;
    logic [31:0] pps_reg, pps_next;
    logic [15:0] spw_reg, spw_next;
    logic [16:0] coef_reg, coef_next;
    logic [31:0] binc_reg, binc_next;
    logic [15:0] bsamp_reg, bsamp_next;

    logic [PHASE_W-1:0] phase_reg [VOICE_COUNT];
    logic [PHASE_W-1:0] phase_next [VOICE_COUNT];
    logic [STEP_W-1:0]  step_reg [VOICE_COUNT];
    logic [STEP_W-1:0]  step_next [VOICE_COUNT];
    logic [VOL_W-1:0]   vol_reg [VOICE_COUNT];
    logic [VOL_W-1:0]   vol_next [VOICE_COUNT];

    logic [1:0]  top_reg, top_next;
    logic [1:0]  cur_reg, cur_next;
    logic        chord_reg, chord_next;
    logic [15:0] wsl_reg, wsl_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic        running_reg, running_next;
    logic [15:0] bleft_reg, bleft_next;
    logic [31:0] bphase_reg, bphase_next;
    logic        taken_reg, taken_next;

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [PROD_W-1:0] prod_a_reg, prod_a_next;

    logic        out_valid_reg, out_valid_next;
    logic signed [15:0] sample_reg, sample_next;
    logic        word_taken_reg, word_taken_next;
    logic        music_active_reg, music_active_next;

    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [STEP_W-1:0]     div_quotient;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;

    logic signed [MUL_X_W-1:0] mul_x;
    logic signed [MUL_Y_W-1:0] mul_y;
    logic signed [PROD_W-1:0]  mul_product;

    logic [16:0]               coef_sat;
    logic                      clear_music;
    logic                      write_step;
    logic [STEP_W-1:0]         step_value;
    logic [1:0]                top_sel;
    logic                      run_after;
    logic signed [SUM_W-1:0]   sum_acc;
    logic signed [PROD_W-1:0]  acc_wide;
    logic signed [ACC_W-1:0]   acc_adj;
    logic signed [MUSIC_W-1:0] music;
    logic [31:0]               bphase_new;
    logic signed [AUDIO_W-1:0] audio;

    fvsb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .num      (div_num),
        .den      (div_den),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    fvsb_mul u_mul (
        .clk     (clk),
        .x       (mul_x),
        .y       (mul_y),
        .product (mul_product)
    );

    assign coef_sat  = (coef_reg > COEF_ONE) ? COEF_ONE : coef_reg;
    assign div_num   = {pps_reg, 8'd0};
    assign div_den   = {word[14:0], 2'b10};
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        mute_next         = mute_reg;
        pps_next          = pps_reg;
        spw_next          = spw_reg;
        coef_next         = coef_reg;
        binc_next         = binc_reg;
        bsamp_next        = bsamp_reg;
        phase_next        = phase_reg;
        step_next         = step_reg;
        vol_next          = vol_reg;
        top_next          = top_reg;
        cur_next          = cur_reg;
        chord_next        = chord_reg;
        wsl_next          = wsl_reg;
        acc_next          = acc_reg;
        running_next      = running_reg;
        bleft_next        = bleft_reg;
        bphase_next       = bphase_reg;
        taken_next        = taken_reg;
        sum_next          = sum_reg;
        prod_a_next       = prod_a_reg;
        out_valid_next    = out_valid_reg;
        sample_next       = sample_reg;
        word_taken_next   = word_taken_reg;
        music_active_next = music_active_reg;
        div_ctrl.start    = 1'b0;
        mul_x             = '0;
        mul_y             = '0;
        clear_music       = 1'b0;
        write_step        = 1'b0;
        step_value        = '0;
        top_sel           = (word[13:12] > 2'(VOICE_COUNT - 1)) ? 2'(VOICE_COUNT - 1)
                                                                 : word[13:12];
        run_after         = running_reg;
        sum_acc           = '0;
        acc_wide          = prod_a_reg + (mul_product <<< 16);
        acc_adj           = acc_reg + (acc_reg[ACC_W-1] ? ACC_ROUND : '0);
        music             = running_reg ? MUSIC_W'(acc_adj >>> 16) : '0;
        bphase_new        = bphase_reg + binc_reg;
        audio             = AUDIO_W'(music);

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MUTE:             mute_next  = cfg_data[0];
                REG_PHASE_PER_SAMPLE: pps_next   = cfg_data;
                REG_SAMPLES_PER_WORD: spw_next   = cfg_data[15:0];
                REG_FILTER_COEF:      coef_next  = cfg_data[16:0];
                REG_BEEP_INCREMENT:   binc_next  = cfg_data;
                REG_BEEP_SAMPLES:     bsamp_next = cfg_data[15:0];
                default:              ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_START:
                        begin
                            clear_music  = 1'b1;
                            acc_next     = '0;
                        end
                        CMD_STOP:
                        begin
                            clear_music  = 1'b1;
                        end
                        CMD_BEEP:
                        begin
                            bleft_next = bsamp_reg;
                        end
                        CMD_TICK:
                        begin
                            taken_next = 1'b0;
                            state_next = running_reg ? ST_SUM : ST_OUT;
                            if (running_reg && wsl_reg == '0)
                            begin
                                taken_next = 1'b1;
                                if (word_kind == KIND_END)
                                begin
                                    clear_music = 1'b1;
                                    run_after   = 1'b0;
                                    state_next  = ST_OUT;
                                end
                                else
                                begin
                                    wsl_next = (spw_reg == '0) ? 16'd1 : spw_reg;
                                    if (word_kind == KIND_DATA && word[17:16] == WORD_TAG)
                                    begin
                                        if (word[15])
                                        begin
                                            if (word[14:0] >= 15'd2)
                                            begin
                                                div_ctrl.start = 1'b1;
                                                state_next     = ST_DIV;
                                            end
                                            else
                                            begin
                                                write_step = 1'b1;
                                            end
                                        end
                                        else
                                        begin
                                            chord_next = word[14];
                                            top_next   = top_sel;
                                            cur_next   = top_sel;
                                            for (int i = 0; i < VOICE_COUNT; i++)
                                            begin
                                                vol_next[i] = volume_of(word[11-3*i -: 3]);
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    write_step = 1'b1;
                    step_value = div_stat.fits ? div_quotient : '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                for (int i = 0; i < VOICE_COUNT; i++)
                begin
                    if (step_reg[i] != '0)
                    begin
                        if (phase_reg[i][30])
                        begin
                            sum_acc = sum_acc - SUM_W'(vol_reg[i]);
                        end
                        else
                        begin
                            sum_acc = sum_acc + SUM_W'(vol_reg[i]);
                        end
                        phase_next[i] = phase_reg[i] + PHASE_W'(step_reg[i]);
                    end
                end
                sum_next   = sum_acc;
                wsl_next   = wsl_reg - 16'd1;
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                mul_x      = acc_reg;
                mul_y      = signed'({1'b0, COEF_ONE - coef_sat});
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                mul_x       = MUL_X_W'(sum_reg);
                mul_y       = signed'({1'b0, coef_sat});
                prod_a_next = mul_product;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = ACC_W'(acc_wide >>> 16);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (bleft_reg != '0)
                    begin
                        bphase_next = bphase_new;
                        bleft_next  = bleft_reg - 16'd1;
                        audio       = audio + (bphase_new[31] ? BEEP_NEG : BEEP_POS);
                    end
                    if (audio > SAT_POS)
                    begin
                        audio = SAT_POS;
                    end
                    else if (audio < SAT_NEG)
                    begin
                        audio = SAT_NEG;
                    end
                    sample_next       = mute_reg ? '0 : 16'(audio);
                    word_taken_next   = taken_reg;
                    music_active_next = running_reg;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (write_step)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                if (2'(i) == cur_reg)
                begin
                    step_next[i] = step_value;
                end
            end
            if (!chord_reg)
            begin
                cur_next = (cur_reg == 2'd0) ? top_reg : cur_reg - 2'd1;
            end
        end

        if (clear_music)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                phase_next[i] = '0;
                step_next[i]  = '0;
                vol_next[i]   = '0;
            end
            top_next     = '0;
            cur_next     = '0;
            chord_next   = 1'b0;
            wsl_next     = '0;
            running_next = run_after && (cmd_t'(cmd) == CMD_START);
        end
        if (state_reg == ST_IDLE && in_valid && cmd_t'(cmd) == CMD_START)
        begin
            running_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            mute_reg         <= 1'b0;
            pps_reg          <= RST_PHASE_PER_SAMPLE;
            spw_reg          <= RST_SAMPLES_PER_WORD;
            coef_reg         <= RST_FILTER_COEF;
            binc_reg         <= RST_BEEP_INCREMENT;
            bsamp_reg        <= RST_BEEP_SAMPLES;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                phase_reg[i] <= '0;
                step_reg[i]  <= '0;
                vol_reg[i]   <= '0;
            end
            top_reg          <= '0;
            cur_reg          <= '0;
            chord_reg        <= 1'b0;
            wsl_reg          <= '0;
            acc_reg          <= '0;
            running_reg      <= 1'b0;
            bleft_reg        <= '0;
            bphase_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            mute_reg         <= mute_next;
            pps_reg          <= pps_next;
            spw_reg          <= spw_next;
            coef_reg         <= coef_next;
            binc_reg         <= binc_next;
            bsamp_reg        <= bsamp_next;
            phase_reg        <= phase_next;
            step_reg         <= step_next;
            vol_reg          <= vol_next;
            top_reg          <= top_next;
            cur_reg          <= cur_next;
            chord_reg        <= chord_next;
            wsl_reg          <= wsl_next;
            acc_reg          <= acc_next;
            running_reg      <= running_next;
            bleft_reg        <= bleft_next;
            bphase_reg       <= bphase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        taken_reg        <= taken_next;
        sum_reg          <= sum_next;
        prod_a_reg       <= prod_a_next;
        sample_reg       <= sample_next;
        word_taken_reg   <= word_taken_next;
        music_active_reg <= music_active_next;
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign word_taken   = word_taken_reg;
    assign music_active = music_active_reg;

`ifndef ASSERT_OFF
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished while sequencer not waiting");

    a_div_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |=> state_reg == ST_DIV)
        else $error("divider started without sequencer entering divide");
`endif

endmodule

/* hdl/fvsb_div.sv */
// Restoring divider, one quotient bit per cycle, for voice pitch steps.
module fvsb_div
    import fvsb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctrl_t            ctrl,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output div_stat_t            stat,
    output logic [STEP_W-1:0]    quotient
);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.done = done_reg;
    assign stat.fits = (quo_reg[DIV_NUM_W-1:STEP_W-1] == '0)
                    || (quo_reg == DIV_LIMIT && rem_reg == '0);
    assign quotient  = quo_reg[STEP_W-1:0];

endmodule

/* hdl/fvsb_mul.sv */
// Shared signed multiplier with a registered product for the filter.
module fvsb_mul
    import fvsb_pkg::*;
(
    input  logic                       clk,
    input  logic signed [MUL_X_W-1:0]  x,
    input  logic signed [MUL_Y_W-1:0]  y,
    output logic signed [PROD_W-1:0]   product
);

    logic signed [PROD_W-1:0] product_reg, product_next;

    always_comb
    begin
        product_next = x * y;
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule
